@@ src/tre_pkg.sv @@
// Shared widths, stage counts and types for the TDOA residual evaluator.
package tre_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int IDX_W        = 8;
  localparam int COORD_W      = 32;
  localparam int DELAY_W      = 40;
  localparam int C_W          = 32;
  localparam int FS_W         = 27;
  localparam int RES_W        = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  // distance path
  localparam int DIFF_W   = 32;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SQ_N     = SUM_W / 2;
  localparam int SQ_REM_W = ROOT_W + 2;

  // scaling path
  localparam int DDIST_W = ROOT_W + 1;
  localparam int PL_W    = 32 + C_W;
  localparam int PH_W    = (DELAY_W - 32) + C_W;
  localparam int T2_W    = DELAY_W + C_W;
  localparam int NUM_W   = T2_W + 2;
  localparam int NABS_W  = T2_W + 1;
  localparam int PP_W    = 32 + FS_W;
  localparam int PP2_W   = (NABS_W - 64) + FS_W;
  localparam int PROD_W  = NABS_W + FS_W;

  // divider
  localparam int DEN_SH = 24;
  localparam int LIM_SH = RES_W + DEN_SH;
  localparam int DREM_W = C_W + LIM_SH;
  localparam int DIV_N  = RES_W;

  localparam int FRONT_N = 3;
  localparam int SCALE_N = 7;
  localparam int N_STAGE = 1 + FRONT_N + SQ_N + SCALE_N + 1 + DIV_N;

  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd1;

  localparam logic [C_W-1:0]  SOUND_SPEED_RST = 32'd100925440;
  localparam logic [FS_W-1:0] SAMPLE_RATE_RST = 27'd40000000;

  // [0] = x, [1] = y, [2] = z
  typedef logic [2:0][COORD_W-1:0] pos_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [RES_W-1:0] residual;
    logic             sat;
  } res_t;

endpackage

@@ src/tre_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tre_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ src/tre_front.sv @@
// Coordinate differences, squares and sums of squares for both distances.
module tre_front import tre_pkg::*; (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  pos_t                      pos_a_i,
  input  pos_t                      pos_b_i,
  input  pos_t                      pos_r_i,
  input  logic signed [DELAY_W-1:0] delay_i,
  output logic [SUM_W-1:0]          sum_a_o,
  output logic [SUM_W-1:0]          sum_b_o,
  output logic signed [DELAY_W-1:0] delay_o
);

  function automatic logic [DIFF_W-1:0] abs_diff(logic [COORD_W-1:0] p,
                                                 logic [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    d = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    return d[COORD_W] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [DIFF_W-1:0]         ad_a_q [3];
  logic [DIFF_W-1:0]         ad_b_q [3];
  logic [SQ_W-1:0]           sq_a_q [3];
  logic [SQ_W-1:0]           sq_b_q [3];
  logic signed [DELAY_W-1:0] dly1_q, dly2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int n = 0; n < 3; n++) begin
        ad_a_q[n] <= abs_diff(pos_a_i[n], pos_r_i[n]);
        ad_b_q[n] <= abs_diff(pos_b_i[n], pos_r_i[n]);
        sq_a_q[n] <= SQ_W'(ad_a_q[n]) * SQ_W'(ad_a_q[n]);
        sq_b_q[n] <= SQ_W'(ad_b_q[n]) * SQ_W'(ad_b_q[n]);
      end
      sum_a_o <= SUM_W'(sq_a_q[0]) + SUM_W'(sq_a_q[1]) + SUM_W'(sq_a_q[2]);
      sum_b_o <= SUM_W'(sq_b_q[0]) + SUM_W'(sq_b_q[1]) + SUM_W'(sq_b_q[2]);
      dly1_q  <= delay_i;
      dly2_q  <= dly1_q;
      delay_o <= dly2_q;
    end
  end

endmodule

@@ src/tre_sqrt.sv @@
// Two-lane pipelined integer square root, one radicand bit pair per stage.
module tre_sqrt import tre_pkg::*; (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic [SUM_W-1:0]          sum_a_i,
  input  logic [SUM_W-1:0]          sum_b_i,
  input  logic signed [DELAY_W-1:0] delay_i,
  output logic [ROOT_W-1:0]         root_a_o,
  output logic [ROOT_W-1:0]         root_b_o,
  output logic signed [DELAY_W-1:0] delay_o
);

  function automatic sq_t sq_step(sq_t s, logic [1:0] pr);
    logic [SQ_REM_W+1:0] r;
    logic [SQ_REM_W+1:0] t;
    sq_t                 o;
    r = {s.rem, pr};
    t = (SQ_REM_W + 2)'({s.root, 2'b01});
    if (r >= t) begin
      o.rem  = SQ_REM_W'(r - t);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = SQ_REM_W'(r);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [1:0][SUM_W-1:0]     sum_w;
  logic [SUM_W-1:0]          rad_q  [2][SQ_N-1];
  sq_t                       st_q   [2][SQ_N-1];
  logic [ROOT_W-1:0]         root_q [2];
  logic signed [DELAY_W-1:0] dly_q  [SQ_N];

  assign sum_w = {sum_b_i, sum_a_i};

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar j = 0; j < SQ_N; j++) begin : g_st
      sq_t              prev;
      logic [SUM_W-1:0] prad;
      sq_t              nxt;
      if (j == 0) begin : g_first
        assign prev = '0;
        assign prad = sum_w[l];
      end else begin : g_next
        assign prev = st_q[l][j-1];
        assign prad = rad_q[l][j-1];
      end
      assign nxt = sq_step(prev, prad[SUM_W-1 -: 2]);
      if (j < SQ_N - 1) begin : g_mid
        always_ff @(posedge clk_i) begin
          if (adv_i) begin
            st_q[l][j]  <= nxt;
            rad_q[l][j] <= prad << 2;
          end
        end
      end else begin : g_last
        always_ff @(posedge clk_i) begin
          if (adv_i) begin
            root_q[l] <= nxt.root;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dly_q[0] <= delay_i;
      for (int j = 1; j < SQ_N; j++) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  assign root_a_o = root_q[0];
  assign root_b_o = root_q[1];
  assign delay_o  = dly_q[SQ_N-1];

endmodule

@@ src/tre_scale.sv @@
// Range difference against measured delay times c, then scaling by fs.
module tre_scale import tre_pkg::*; (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic [ROOT_W-1:0]         root_a_i,
  input  logic [ROOT_W-1:0]         root_b_i,
  input  logic signed [DELAY_W-1:0] delay_i,
  input  logic [C_W-1:0]            sound_speed_i,
  input  logic [FS_W-1:0]           sample_rate_i,
  output logic [PROD_W-1:0]         prod_o
);

  logic signed [DDIST_W-1:0] dd1_q, dd2_q, dd3_q;
  logic                      dneg1_q, dneg2_q, dneg3_q;
  logic [DELAY_W-1:0]        dmag_q;
  logic [PL_W-1:0]           pl_q;
  logic [PH_W-1:0]           ph_q;
  logic [T2_W-1:0]           t2_q;
  logic signed [NUM_W-1:0]   num_q;
  logic [NABS_W-1:0]         nabs_q;
  logic [PP_W-1:0]           pp0_q, pp1_q;
  logic [PP2_W-1:0]          pp2_q;
  logic signed [NUM_W-1:0]   t1;
  logic signed [NUM_W-1:0]   t2s;

  // range difference in Q.32 against signed delay*c
  assign t1  = NUM_W'(dd3_q) <<< 32;
  assign t2s = dneg3_q ? $signed(NUM_W'(t2_q)) : -$signed(NUM_W'(t2_q));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dd1_q   <= $signed({1'b0, root_b_i}) - $signed({1'b0, root_a_i});
      dneg1_q <= delay_i[DELAY_W-1];
      dmag_q  <= delay_i[DELAY_W-1] ? DELAY_W'(-delay_i) : DELAY_W'(delay_i);

      dd2_q   <= dd1_q;
      dneg2_q <= dneg1_q;
      pl_q    <= PL_W'(dmag_q[31:0]) * PL_W'(sound_speed_i);
      ph_q    <= PH_W'(dmag_q[DELAY_W-1:32]) * PH_W'(sound_speed_i);

      dd3_q   <= dd2_q;
      dneg3_q <= dneg2_q;
      t2_q    <= T2_W'(pl_q) + (T2_W'(ph_q) << 32);

      num_q   <= t1 + t2s;

      nabs_q  <= num_q[NUM_W-1] ? NABS_W'(-num_q) : NABS_W'(num_q);

      pp0_q   <= PP_W'(nabs_q[31:0]) * PP_W'(sample_rate_i);
      pp1_q   <= PP_W'(nabs_q[63:32]) * PP_W'(sample_rate_i);
      pp2_q   <= PP2_W'(nabs_q[NABS_W-1:64]) * PP2_W'(sample_rate_i);

      prod_o  <= PROD_W'(pp0_q) + (PROD_W'(pp1_q) << 32) + (PROD_W'(pp2_q) << 64);
    end
  end

endmodule

@@ src/tre_div.sv @@
// Saturation check and restoring divide by c*2^24, one quotient bit per stage.
module tre_div import tre_pkg::*; (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [PROD_W-1:0] prod_i,
  input  logic [C_W-1:0]    sound_speed_i,
  output res_t              res_o
);

  logic [DREM_W-1:0] rem_q [DIV_N];
  logic [RES_W-1:0]  q_q   [DIV_N];
  logic              sat_q [DIV_N+1];
  logic [DREM_W-1:0] den;

  assign den = DREM_W'({sound_speed_i, {DEN_SH{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sat_q[0] <= prod_i >= (PROD_W'(sound_speed_i) << LIM_SH);
      rem_q[0] <= prod_i[DREM_W-1:0];
    end
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_st
    logic [DREM_W-1:0] s;
    logic              take;
    logic [RES_W-1:0]  qprev;
    assign s    = den << (DIV_N - 1 - j);
    assign take = rem_q[j] >= s;
    if (j == 0) begin : g_first
      assign qprev = '0;
    end else begin : g_next
      assign qprev = q_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        q_q[j]     <= {qprev[RES_W-2:0], take};
        sat_q[j+1] <= sat_q[j];
      end
    end
    if (j < DIV_N - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[j+1] <= take ? rem_q[j] - s : rem_q[j];
        end
      end
    end
  end

  assign res_o.residual = sat_q[DIV_N] ? '1 : q_q[DIV_N-1];
  assign res_o.sat      = sat_q[DIV_N];

endmodule

@@ src/tdoa_residual_evaluator.sv @@
// Top level of the TDOA range-difference residual evaluator.
// One item is accepted per clock cycle whenever the output buffer is not
// full. Write items update the position table at acceptance and give no
// result; an evaluate item passes through the table read, three distance
// stages, 33 square-root stages, seven scaling stages, a saturation stage
// and 32 divide stages, and its result may then wait in the two-beat
// output buffer. The latency is set by the square root, one radicand bit
// pair per stage, and the divider, one quotient bit per stage. The
// position table comes up undefined after reset and needs no clearing;
// only written entries may be evaluated.
module tdoa_residual_evaluator import tre_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      op_i,
  input  logic [IDX_W-1:0]          elem_a_i,
  input  logic [IDX_W-1:0]          elem_b_i,
  input  logic [IDX_W-1:0]          elem_ref_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic signed [DELAY_W-1:0] measured_delay_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [RES_W-1:0]          residual_o,
  output logic                      saturated_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic [C_W-1:0]            sound_speed_q;
  logic [FS_W-1:0]           sample_rate_q;
  logic [N_STAGE-1:0]        v_q;
  logic                      adv;
  logic                      in_acc;
  logic                      wr_en;
  logic                      ok_a, ok_b, ok_r;
  logic                      ok_a_q, ok_b_q, ok_r_q;
  logic signed [DELAY_W-1:0] dly0_q;
  pos_t                      wpos;
  pos_t                      ram_a, ram_b, ram_r;
  pos_t                      pos_a, pos_b, pos_r;
  logic [SUM_W-1:0]          sum_a, sum_b;
  logic signed [DELAY_W-1:0] dly3, dly_sq;
  logic [ROOT_W-1:0]         root_a, root_b;
  logic [PROD_W-1:0]         prod;
  res_t                      res;
  res_t                      buf0_q, buf0_d, buf1_q, buf1_d;
  logic [1:0]                cnt_q, cnt_d;
  logic                      push, pop;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_speed_q <= SOUND_SPEED_RST;
      sample_rate_q <= SAMPLE_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOUND_SPEED: sound_speed_q <= cfg_wdata_i[C_W-1:0];
        CFG_SAMPLE_RATE: sample_rate_q <= cfg_wdata_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless the last stage holds a result, the buffer is full and out_ready_i is low
  assign adv        = !v_q[N_STAGE-1] || (cnt_q != 2'd2) || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  assign ok_a  = 32'(elem_a_i) < MAX_ELEMENTS;
  assign ok_b  = 32'(elem_b_i) < MAX_ELEMENTS;
  assign ok_r  = 32'(elem_ref_i) < MAX_ELEMENTS;
  assign wr_en = in_acc && !op_i && ok_a;
  assign wpos  = {coord_z_i, coord_y_i, coord_x_i};

  tre_ram #(.Width($bits(pos_t)), .Depth(MAX_ELEMENTS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(elem_a_i)),
    .wdata_i (wpos),
    .re_i    (adv),
    .raddr_i (ADDR_W'(elem_a_i)),
    .rdata_o (ram_a)
  );

  tre_ram #(.Width($bits(pos_t)), .Depth(MAX_ELEMENTS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(elem_a_i)),
    .wdata_i (wpos),
    .re_i    (adv),
    .raddr_i (ADDR_W'(elem_b_i)),
    .rdata_o (ram_b)
  );

  tre_ram #(.Width($bits(pos_t)), .Depth(MAX_ELEMENTS)) u_ram_r (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(elem_a_i)),
    .wdata_i (wpos),
    .re_i    (adv),
    .raddr_i (ADDR_W'(elem_ref_i)),
    .rdata_o (ram_r)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_a_q <= ok_a;
      ok_b_q <= ok_b;
      ok_r_q <= ok_r;
      dly0_q <= measured_delay_i;
    end
  end

  // an index past the table reads as the origin
  assign pos_a = ok_a_q ? ram_a : '0;
  assign pos_b = ok_b_q ? ram_b : '0;
  assign pos_r = ok_r_q ? ram_r : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[N_STAGE-2:0], in_valid_i && op_i};
    end
  end

  tre_front u_front (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .pos_a_i (pos_a),
    .pos_b_i (pos_b),
    .pos_r_i (pos_r),
    .delay_i (dly0_q),
    .sum_a_o (sum_a),
    .sum_b_o (sum_b),
    .delay_o (dly3)
  );

  tre_sqrt u_sqrt (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sum_a_i  (sum_a),
    .sum_b_i  (sum_b),
    .delay_i  (dly3),
    .root_a_o (root_a),
    .root_b_o (root_b),
    .delay_o  (dly_sq)
  );

  tre_scale u_scale (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .root_a_i      (root_a),
    .root_b_i      (root_b),
    .delay_i       (dly_sq),
    .sound_speed_i (sound_speed_q),
    .sample_rate_i (sample_rate_q),
    .prod_o        (prod)
  );

  tre_div u_div (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .prod_i        (prod),
    .sound_speed_i (sound_speed_q),
    .res_o         (res)
  );

  // two-beat output buffer, head in buf0
  assign push = adv && v_q[N_STAGE-1];
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
    if (pop) begin
      buf0_d = buf1_q;
    end
    if (push) begin
      if ((cnt_q - 2'(pop)) == 2'd0) begin
        buf0_d = res;
      end else begin
        buf1_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign residual_o  = buf0_q.residual;
  assign saturated_o = buf0_q.sat;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> residual_o == '1)
    else $error("saturated beat without clamped residual");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v_q[N_STAGE-1] && cnt_q == 2'd2 && !out_ready_i))
    else $error("input stalled without a full output buffer");

  a_eval_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i) |=> v_q[0])
    else $error("accepted evaluate beat did not enter the pipeline");

endmodule
